>>> sv/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg: shared types and constants for the sRGB contrast stretch
// Holds the back-end state type and the elaboration-time sRGB linear table math.
// ----------------------------------------------------------------------------
package scs_pkg;

    // fine table precision (fraction bits of the 0.24 intermediate)
    localparam int FineBits = 24;

    // back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_HOLD
    } t_back_state;

    // x^5 in 0.32 fixed point
    function automatic logic [63:0] pow5_q32(input logic [63:0] r);
        logic [63:0] a;
        logic [63:0] b;
        a = (r * r) >> 32;
        b = (a * a) >> 32;
        return (b * r) >> 32;
    endfunction

    // sRGB byte to linear in 0.24, constant use only
    function automatic logic [63:0] fine_linear(input logic [7:0] k);
        logic [63:0] n;
        logic [63:0] t;
        logic [63:0] w;
        logic [63:0] r;
        logic [63:0] cand;
        if (k <= 8'd10) begin
            return (64'(k) * 64'd5 * (64'd1 << 24) + 64'd8236) / 64'd16473;
        end
        if (k == 8'd255) begin
            return 64'd1 << 24;
        end
        n = 64'd1000 * 64'(k) + 64'd14025;
        t = ((n << 32) + 64'd134512) / 64'd269025;
        w = (t * t + (64'd1 << 31)) >> 32;
        r = 64'd0;
        for (int bit_i = 31; bit_i >= 0; bit_i--) begin
            cand = r | (64'd1 << bit_i);
            if (pow5_q32(cand) <= w) begin
                r = cand;
            end
        end
        return (w * r + (64'd1 << 39)) >> 40;
    endfunction

    // table entry at lb fraction bits, rounded and saturated
    function automatic logic [FineBits-1:0] lin_entry(input logic [7:0] k, input int lb);
        logic [63:0] f;
        logic [63:0] half;
        logic [63:0] v;
        logic [63:0] vmax;
        f    = fine_linear(k);
        half = (64'd1 << (FineBits - lb)) >> 1;
        v    = (f + half) >> (FineBits - lb);
        vmax = (64'd1 << lb) - 64'd1;
        if (v > vmax) begin
            v = vmax;
        end
        return v[FineBits-1:0];
    endfunction

endpackage

>>> sv/scs_if.sv
// ----------------------------------------------------------------------------
// scs_if: pixel channels of the sRGB contrast stretch
// Input pixel channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface scs_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic       frame_start;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, action, frame_start, red_in, green_in, blue_in,
                    input ready);
    modport sink   (input valid, action, frame_start, red_in, green_in, blue_in,
                    output ready);
endinterface

interface scs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       flat_image;

    modport source (output valid, red_out, green_out, blue_out, flat_image,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, flat_image,
                    output ready);
endinterface

>>> sv/scs_front.sv
// ----------------------------------------------------------------------------
// scs_front: pixel intake, linearization and min/max tracking
// Measure pixels fold into the tracked range; correct pixels go to the queue
// together with the range they must be stretched against.
// ----------------------------------------------------------------------------
module scs_front #(
    parameter int LB = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_action,
    input  logic            i_frame_start,
    input  logic [7:0]      i_red,
    input  logic [7:0]      i_green,
    input  logic [7:0]      i_blue,
    output logic            o_push,
    input  logic            i_full,
    output logic [5*LB-1:0] o_data
);
    import scs_pkg::*;

    localparam logic [LB-1:0] LinMax = {LB{1'b1}};

    logic [LB-1:0] w_tab [256];
    logic          r_v;
    logic          r_act;
    logic          r_fs;
    logic [LB-1:0] r_lin [3];
    logic [LB-1:0] r_lo;
    logic [LB-1:0] r_hi;
    logic [LB-1:0] n_lo;
    logic [LB-1:0] n_hi;
    logic          w_take;
    logic          w_done;

    // constant sRGB linear table
    for (genvar g = 0; g < 256; g++) begin : g_tab
        assign w_tab[g] = LB'(lin_entry(8'(g), LB));
    end

    // stage is free when empty or when its item leaves this cycle
    assign w_done  = r_v && (!r_act || !i_full);
    assign o_ready = !r_v || w_done;
    assign w_take  = i_valid && o_ready;
    assign o_push  = r_v && r_act && !i_full;
    assign o_data  = {r_hi, r_lo, r_lin[2], r_lin[1], r_lin[0]};

    // intake stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_take) begin
            r_v <= 1'b1;
        end else if (w_done) begin
            r_v <= 1'b0;
        end
        if (w_take) begin
            r_act    <= i_action;
            r_fs     <= i_frame_start;
            r_lin[0] <= w_tab[i_red];
            r_lin[1] <= w_tab[i_green];
            r_lin[2] <= w_tab[i_blue];
        end
    end

    // range update for a measure pixel
    always_comb begin
        n_lo = (r_fs) ? LinMax : r_lo;
        n_hi = (r_fs) ? '0 : r_hi;
        for (int c = 0; c < 3; c++) begin
            if (r_lin[c] < n_lo) begin
                n_lo = r_lin[c];
            end
            if (r_lin[c] > n_hi) begin
                n_hi = r_lin[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= LinMax;
            r_hi <= '0;
        end else if (r_v && !r_act) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
    end

endmodule

>>> sv/scs_queue.sv
// ----------------------------------------------------------------------------
// scs_queue: two-entry queue between front and back
// Decouples range tracking from the iterative encoder.
// ----------------------------------------------------------------------------
module scs_queue #(
    parameter int W = 80
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    import scs_pkg::*;

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         w_wr;
    logic         w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= !r_wp;
            end
            if (w_rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

endmodule

>>> sv/scs_back.sv
// ----------------------------------------------------------------------------
// scs_back: stretch and gamma encode, three channel lanes
// Each lane finds its output byte by an 8-step binary search over the linear
// table, one multiply and compare per step, then holds the result.
// ----------------------------------------------------------------------------
module scs_back #(
    parameter int LB = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  logic [5*LB-1:0] i_data,
    output logic            o_pop,
    scs_out_if.source       o_pix
);
    import scs_pkg::*;

    logic [LB-1:0]   w_tab [256];
    t_back_state     r_state;
    t_back_state     n_state;
    logic [2:0]      r_step;
    logic [LB-1:0]   r_span;
    logic            r_flat;
    logic [2*LB-1:0] r_num [3];
    logic [7:0]      r_cnt [3];
    logic [2:0]      r_fix;
    logic [LB-1:0]   w_lo;
    logic [LB-1:0]   w_hi;
    logic [LB-1:0]   w_v [3];
    logic            w_flat;
    logic [7:0]      w_cand [3];
    logic [2*LB-1:0] w_prod [3];
    logic            w_load;

    for (genvar g = 0; g < 256; g++) begin : g_tab
        assign w_tab[g] = LB'(lin_entry(8'(g), LB));
    end

    assign w_v[0] = i_data[LB-1:0];
    assign w_v[1] = i_data[2*LB-1:LB];
    assign w_v[2] = i_data[3*LB-1:2*LB];
    assign w_lo   = i_data[4*LB-1:3*LB];
    assign w_hi   = i_data[5*LB-1:4*LB];
    assign w_flat = (w_hi <= w_lo);

    // sequencer
    always_comb begin
        n_state = r_state;
        w_load  = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    w_load  = 1'b1;
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (r_step == 3'd0) begin
                    n_state = BK_HOLD;
                end
            end
            BK_HOLD: begin
                if (o_pix.ready) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    assign o_pop = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // search probe per lane
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_cand[c] = r_cnt[c] | (8'd1 << r_step);
            w_prod[c] = (2*LB)'(w_tab[w_cand[c]]) * (2*LB)'(r_span);
        end
    end

    // lane datapath
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_step <= 3'd7;
            r_span <= w_hi - w_lo;
            r_flat <= w_flat;
            for (int c = 0; c < 3; c++) begin
                r_num[c] <= {w_v[c] - w_lo, {LB{1'b0}}};
                if (w_flat || w_v[c] <= w_lo) begin
                    r_cnt[c] <= 8'd0;
                    r_fix[c] <= 1'b1;
                end else if (w_v[c] >= w_hi) begin
                    r_cnt[c] <= 8'd255;
                    r_fix[c] <= 1'b1;
                end else begin
                    r_cnt[c] <= 8'd0;
                    r_fix[c] <= 1'b0;
                end
            end
        end else if (r_state == BK_RUN) begin
            r_step <= r_step - 3'd1;
            for (int c = 0; c < 3; c++) begin
                if (!r_fix[c] && w_prod[c] <= r_num[c]) begin
                    r_cnt[c] <= w_cand[c];
                end
            end
        end
    end

    assign o_pix.valid      = (r_state == BK_HOLD);
    assign o_pix.red_out    = r_cnt[0];
    assign o_pix.green_out  = r_cnt[1];
    assign o_pix.blue_out   = r_cnt[2];
    assign o_pix.flat_image = r_flat;

endmodule

>>> sv/srgb_contrast_stretch.sv
// ----------------------------------------------------------------------------
// srgb_contrast_stretch: two-pass min/max contrast stretch of sRGB pixels
// Pixels enter on i_pix. action 0 measures: the three channels are linearized
// and fold into the tracked min/max (frame_start restarts the range first);
// no item comes out. action 1 corrects: one item leaves on o_pix with each
// channel stretched to (v-min)/(max-min) and re-encoded to an sRGB byte, or
// zeros and flat_image when max <= min.
// Measure pixels are taken one per cycle while the intake stage is free. A correct
// pixel passes the intake stage, waits in a 2-entry queue, then the encoder
// loads it, runs 8 binary-search steps each with one LINEAR_BITS-wide multiply
// per lane, and presents the result. It takes no new correct pixel until that
// result is accepted, so the search loop and any output stall set the rate.
// Reset (i_rst_n low, synchronous) empties the pipeline and sets the range to
// min all ones, max zero. When the receiver holds o_pix.ready low the result
// stays put, the queue fills, and once a correct pixel is stuck in the intake
// stage i_pix.ready drops for every pixel.
// ----------------------------------------------------------------------------
module srgb_contrast_stretch #(
    parameter int LINEAR_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    scs_in_if.sink    i_pix,
    scs_out_if.source o_pix
);
    import scs_pkg::*;

    localparam int EntryW = 5 * LINEAR_BITS;

    logic              w_push;
    logic              w_full;
    logic              w_pop;
    logic              w_empty;
    logic [EntryW-1:0] w_qin;
    logic [EntryW-1:0] w_qout;

    scs_front #(.LB(LINEAR_BITS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_pix.valid),
        .o_ready       (i_pix.ready),
        .i_action      (i_pix.action),
        .i_frame_start (i_pix.frame_start),
        .i_red         (i_pix.red_in),
        .i_green       (i_pix.green_in),
        .i_blue        (i_pix.blue_in),
        .o_push        (w_push),
        .i_full        (w_full),
        .o_data        (w_qin)
    );

    scs_queue #(.W(EntryW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_qin),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_qout)
    );

    scs_back #(.LB(LINEAR_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_data  (w_qout),
        .o_pop   (w_pop),
        .o_pix   (o_pix)
    );

endmodule

>>> test/tb_srgb_contrast_stretch.sv
// ----------------------------------------------------------------------------
// tb_srgb_contrast_stretch: self-checking bench for the sRGB contrast stretch
// Drives measure and correct pixels through the valid/ready input, predicts
// each corrected pixel from a local sRGB table and tracked range, and checks
// every result item in order under several idling and backpressure phases.
// ----------------------------------------------------------------------------
module tb_srgb_contrast_stretch;
    import scs_pkg::*;

    localparam int LinBits   = 16;
    localparam int StallLimit = 20000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       flat;
    } t_pixel_result;

    logic i_clk;
    logic i_rst_n;

    scs_in_if  pix_in ();
    scs_out_if pix_out ();

    srgb_contrast_stretch #(.LINEAR_BITS(LinBits)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in.sink),
        .o_pix   (pix_out.source)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // predictor state
    logic [LinBits-1:0] srgb_lin [256];
    logic [LinBits-1:0] range_lo;
    logic [LinBits-1:0] range_hi;
    t_pixel_result      expected_pixels [$];
    int                 error_count;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 long_hold;
    int                 quiet_cycles;

    // sRGB byte to linear, 0.24 fixed point (local copy of the curve)
    function automatic longint unsigned fifth_pow(input longint unsigned r);
        longint unsigned a;
        longint unsigned b;
        a = (r * r) >> 32;
        b = (a * a) >> 32;
        return (b * r) >> 32;
    endfunction

    function automatic longint unsigned srgb_to_fine(input int k);
        longint unsigned n;
        longint unsigned t;
        longint unsigned w;
        longint unsigned r;
        longint unsigned c;
        if (k <= 10) return (longint'(k) * 5 * (64'd1 << 24) + 8236) / 16473;
        if (k == 255) return 64'd1 << 24;
        n = 1000 * longint'(k) + 14025;
        t = ((n << 32) + 134512) / 269025;
        w = (t * t + (64'd1 << 31)) >> 32;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (fifth_pow(c) <= w) r = c;
        end
        return (w * r + (64'd1 << 39)) >> 40;
    endfunction

    // table entry at LinBits fraction bits, rounded and saturated
    function automatic logic [LinBits-1:0] srgb_to_lin(input int k);
        longint unsigned v;
        v = (srgb_to_fine(k) + ((64'd1 << (24 - LinBits)) >> 1)) >> (24 - LinBits);
        if (v > (64'd1 << LinBits) - 1) v = (64'd1 << LinBits) - 1;
        return v[LinBits-1:0];
    endfunction

    function automatic logic [7:0] stretch_channel(input logic [LinBits-1:0] v);
        longint unsigned span;
        longint unsigned num;
        int              cnt;
        if (v <= range_lo) return 8'd0;
        if (v >= range_hi) return 8'd255;
        span = range_hi - range_lo;
        num  = longint'(v - range_lo) << LinBits;
        cnt  = 0;
        for (int k = 1; k < 256; k++)
            if (num >= longint'(srgb_lin[k]) * span) cnt++;
        return 8'(cnt);
    endfunction

    // fold one accepted pixel into the predictor
    task automatic predict_pixel(input logic act, input logic fs,
                                 input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b);
        logic [LinBits-1:0] lin [3];
        t_pixel_result      res;
        lin[0] = srgb_lin[r];
        lin[1] = srgb_lin[g];
        lin[2] = srgb_lin[b];
        if (!act) begin
            if (fs) begin
                range_lo = '1;
                range_hi = '0;
            end
            for (int c = 0; c < 3; c++) begin
                if (lin[c] < range_lo) range_lo = lin[c];
                if (lin[c] > range_hi) range_hi = lin[c];
            end
        end else begin
            if (range_hi <= range_lo) begin
                res = '{8'd0, 8'd0, 8'd0, 1'b1};
            end else begin
                res.red   = stretch_channel(lin[0]);
                res.green = stretch_channel(lin[1]);
                res.blue  = stretch_channel(lin[2]);
                res.flat  = 1'b0;
            end
            expected_pixels.push_back(res);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // send one pixel, honoring the sender idle rate; valid stays up after
    // acceptance until the next pixel or an idle cycle replaces it
    task automatic send_pixel(input logic act, input logic fs, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_in.valid       <= 1'b1;
        pix_in.action      <= act;
        pix_in.frame_start <= fs;
        pix_in.red_in      <= r;
        pix_in.green_in    <= g;
        pix_in.blue_in     <= b;
        do @(posedge i_clk); while (!pix_in.ready);
        predict_pixel(act, fs, r, g, b);
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(10));
            default: return 8'($urandom);
        endcase
    endfunction

    // receiver: random stall, plus a long hold when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_out.ready <= 1'b0;
        end else if (long_hold > 0) begin
            long_hold     <= long_hold - 1;
            pix_out.ready <= 1'b0;
        end else begin
            pix_out.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_pixel_result want;
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = expected_pixels.pop_front();
                if (pix_out.red_out !== want.red)
                    report_mismatch("red_out", pix_out.red_out, want.red);
                if (pix_out.green_out !== want.green)
                    report_mismatch("green_out", pix_out.green_out, want.green);
                if (pix_out.blue_out !== want.blue)
                    report_mismatch("blue_out", pix_out.blue_out, want.blue);
                if (pix_out.flat_image !== want.flat)
                    report_mismatch("flat_image", pix_out.flat_image, want.flat);
            end
        end
    end

    // watchdog on cycles with no accepted item
    always @(posedge i_clk) begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > StallLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // directed: unmeasured, flat, extremes, below and above range
    task automatic test_directed();
        send_pixel(1'b1, 1'b0, 8'd10, 8'd200, 8'd255);
        send_pixel(1'b0, 1'b1, 8'd77, 8'd77, 8'd77);
        send_pixel(1'b1, 1'b1, 8'd77, 8'd0, 8'd255);
        send_pixel(1'b0, 1'b1, 8'd0, 8'd255, 8'd128);
        for (int k = 0; k < 8; k++)
            send_pixel(1'b1, 1'b0, 8'(k * 36), 8'(255 - k * 36), 8'(k + 3));
        send_pixel(1'b0, 1'b1, 8'd40, 8'd180, 8'd100);
        send_pixel(1'b0, 1'b0, 8'd5, 8'd60, 8'd100);
        send_pixel(1'b1, 1'b0, 8'd0, 8'd255, 8'd5);
        send_pixel(1'b1, 1'b1, 8'd20, 8'd170, 8'd181);
        send_pixel(1'b1, 1'b0, 8'hAA, 8'h55, 8'hFF);
        send_pixel(1'b1, 1'b0, 8'h55, 8'hAA, 8'h00);
    endtask

    // random frames: measure pass then correct pass, with some noise
    task automatic test_frames(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                send_pixel(1'b0, i == 0, rand_byte(), rand_byte(), rand_byte());
            for (int i = 0; i < len + 2; i++)
                send_pixel(1'b1, 1'($urandom_range(1)), rand_byte(), rand_byte(),
                           rand_byte());
            if ($urandom_range(4) == 0)
                send_pixel(1'($urandom_range(1)), 1'($urandom_range(1)), rand_byte(),
                           rand_byte(), rand_byte());
            sent += 2 * len + 2;
        end
    endtask

    // receiver held off while correct pixels keep coming
    task automatic test_backpressure();
        long_hold = 300;
        for (int i = 0; i < 12; i++)
            send_pixel(1'b1, 1'b0, rand_byte(), rand_byte(), rand_byte());
    endtask

    task automatic drain();
        pix_in.valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    initial begin
        for (int k = 0; k < 256; k++)
            srgb_lin[k] = srgb_to_lin(k);
        range_lo           = '1;
        range_hi           = '0;
        error_count        = 0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        long_hold          = 0;
        quiet_cycles       = 0;
        pix_in.valid       = 1'b0;
        pix_in.action      = 1'b0;
        pix_in.frame_start = 1'b0;
        pix_in.red_in      = 8'd0;
        pix_in.green_in    = 8'd0;
        pix_in.blue_in     = 8'd0;
        pix_out.ready      = 1'b0;
        i_rst_n            = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_frames(170);
        send_idle_pct = 73;
        test_frames(170);
        send_idle_pct  = 0;
        recv_stall_pct = 73;
        test_frames(170);
        send_idle_pct = 24;
        recv_stall_pct = 24;
        test_frames(170);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_backpressure();
        drain();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> files.f
sv/scs_pkg.sv
sv/scs_if.sv
sv/scs_front.sv
sv/scs_queue.sv
sv/scs_back.sv
sv/srgb_contrast_stretch.sv
test/tb_srgb_contrast_stretch.sv
